FILE: rtl/rlfc_pkg.sv
package rlfc_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_LOSS      = 3'd1;
  localparam logic [2:0] PH_LANDING   = 3'd2;
  localparam logic [2:0] PH_LANDED    = 3'd3;
  localparam logic [2:0] PH_MONITOR   = 3'd4;
  localparam logic [2:0] PH_RECOVERED = 3'd5;

  localparam logic [2:0] REG_MONITOR_ENABLE   = 3'd0;
  localparam logic [2:0] REG_FAILURE_PERIOD   = 3'd1;
  localparam logic [2:0] REG_RECOVERY_PERIOD  = 3'd2;
  localparam logic [2:0] REG_THROTTLE_DELAY   = 3'd3;
  localparam logic [2:0] REG_REARM_HOLD       = 3'd4;

  localparam logic [1:0] MODE_RX   = 2'd0;
  localparam logic [1:0] MODE_FAIL = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] time_ms;
    logic        armed;
    logic        throttle_down;
  } evt_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic        failsafe_active;
    logic        link_up;
    logic        rx_flag_write;
    logic        rx_flag_value;
    logic        disarm_pulse;
    logic [15:0] event_count;
  } res_t;

  typedef enum logic [1:0] {
    OP_RX,
    OP_FAIL,
    OP_TICK,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] time_ms;
    logic        armed;
    logic        throttle_down;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: rtl/rlfc_front.sv
module rlfc_front import rlfc_pkg::*; (
  input  logic          evt_valid,
  output logic          evt_stall,
  input  evt_t          evt,
  input  queue_status_t q_status,
  output logic          push,
  output cmd_t          push_cmd
);

  assign evt_stall = q_status.full;
  assign push      = evt_valid && !q_status.full;

  always_comb begin
    push_cmd.time_ms       = evt.time_ms;
    push_cmd.armed         = evt.armed;
    push_cmd.throttle_down = evt.throttle_down;
    unique case (evt.mode)
      MODE_RX:   push_cmd.op = OP_RX;
      MODE_FAIL: push_cmd.op = OP_FAIL;
      MODE_TICK: push_cmd.op = OP_TICK;
      default:   push_cmd.op = OP_NONE;
    endcase
  end

endmodule

FILE: rtl/rlfc_queue.sv
module rlfc_queue import rlfc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          push_cmd,
  input  logic          pop,
  output cmd_t          pop_cmd,
  output queue_status_t status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_cmd      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/rlfc_back.sv
module rlfc_back import rlfc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  queue_status_t q_status,
  input  cmd_t          pop_cmd,
  output logic          pop,
  output logic          res_valid,
  input  logic          res_stall,
  output res_t          res
);

  typedef enum logic [2:0] {
    S_READY = 3'b001,
    S_EXEC  = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t      state;
  cmd_t        cur;
  logic [2:0]  pass_cnt;

  logic        monitor_enable;
  logic [15:0] failure_period_ms;
  logic [15:0] recovery_period_ms;
  logic [15:0] throttle_low_delay_ms;
  logic [15:0] rearm_hold_ms;

  logic [31:0] received_at;
  logic [31:0] failed_at;
  logic [31:0] throttle_low_deadline;
  logic [31:0] rearm_deadline;
  logic [15:0] hold_preset;
  logic [2:0]  phase_reg;
  logic        link_flag;
  logic        active_flag;
  logic [15:0] activation_count;
  logic        wr_flag;
  logic        wval_flag;
  logic        disarm_flag;

  logic [31:0] now_plus_delay;
  logic [31:0] now_plus_hold;
  logic [31:0] tld_eff;
  logic        past_tld;
  logic        past_rearm;
  logic [31:0] rx_gap;
  logic [31:0] fail_gap;
  logic        res_free;

  assign now_plus_delay = cur.time_ms + {16'd0, throttle_low_delay_ms};
  assign now_plus_hold  = cur.time_ms + {16'd0, hold_preset};
  assign tld_eff        = cur.throttle_down ? throttle_low_deadline : now_plus_delay;
  assign past_tld       = cur.time_ms > tld_eff;
  assign past_rearm     = cur.time_ms > rearm_deadline;
  assign rx_gap         = cur.time_ms - failed_at;
  assign fail_gap       = cur.time_ms - received_at;
  assign res_free       = !res_valid || !res_stall;
  assign pop            = (state == S_READY) && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= S_READY;
      res_valid             <= 1'b0;
      pass_cnt              <= '0;
      monitor_enable        <= 1'b0;
      failure_period_ms     <= 16'd600;
      recovery_period_ms    <= 16'd2200;
      throttle_low_delay_ms <= 16'd10000;
      rearm_hold_ms         <= 16'd3000;
      received_at           <= '0;
      failed_at             <= '0;
      throttle_low_deadline <= '0;
      rearm_deadline        <= '0;
      hold_preset           <= '0;
      phase_reg             <= PH_IDLE;
      link_flag             <= 1'b0;
      active_flag           <= 1'b0;
      activation_count      <= '0;
      wr_flag               <= 1'b0;
      wval_flag             <= 1'b0;
      disarm_flag           <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MONITOR_ENABLE:  monitor_enable        <= cfg_data[0];
          REG_FAILURE_PERIOD:  failure_period_ms     <= cfg_data;
          REG_RECOVERY_PERIOD: recovery_period_ms    <= cfg_data;
          REG_THROTTLE_DELAY:  throttle_low_delay_ms <= cfg_data;
          REG_REARM_HOLD:      rearm_hold_ms         <= cfg_data;
          default: ;
        endcase
      end

      if (res_valid && !res_stall && (state != S_EMIT)) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_READY: begin
          if (!q_status.empty) begin
            cur         <= pop_cmd;
            pass_cnt    <= '0;
            wr_flag     <= 1'b0;
            wval_flag   <= 1'b0;
            disarm_flag <= 1'b0;
            state       <= S_EXEC;
          end
        end

        S_EXEC: begin
          if (cur.op == OP_TICK && monitor_enable) begin
            // one phase-machine pass per cycle
            logic again;
            again = 1'b0;
            unique case (phase_reg)
              PH_IDLE: begin
                if (cur.armed) begin
                  if (!cur.throttle_down) begin
                    throttle_low_deadline <= now_plus_delay;
                  end
                  if (!link_flag) begin
                    again = 1'b1;
                    if (past_tld) begin
                      active_flag      <= 1'b1;
                      activation_count <= activation_count + 1'b1;
                      phase_reg        <= PH_LANDED;
                      hold_preset      <= rearm_hold_ms;
                    end else begin
                      phase_reg <= PH_LOSS;
                    end
                  end
                end else begin
                  throttle_low_deadline <= '0;
                end
              end
              PH_LOSS: begin
                if (link_flag) begin
                  phase_reg <= PH_RECOVERED;
                  again = 1'b1;
                end else begin
                  active_flag      <= 1'b1;
                  activation_count <= activation_count + 1'b1;
                  phase_reg        <= PH_LANDED;
                end
              end
              PH_LANDED: begin
                disarm_flag    <= 1'b1;
                rearm_deadline <= now_plus_hold;
                phase_reg      <= PH_MONITOR;
                again = 1'b1;
              end
              PH_MONITOR: begin
                if (link_flag) begin
                  if (past_rearm && !cur.armed) begin
                    phase_reg <= PH_RECOVERED;
                    again = 1'b1;
                  end
                end else begin
                  rearm_deadline <= now_plus_hold;
                end
              end
              PH_RECOVERED: begin
                throttle_low_deadline <= now_plus_delay;
                phase_reg             <= PH_IDLE;
                active_flag           <= 1'b0;
                again = 1'b1;
              end
              default: ;
            endcase
            pass_cnt <= pass_cnt + 1'b1;
            if (!again || (&pass_cnt)) begin
              state <= S_EMIT;
            end
          end else begin
            case (cur.op)
              OP_RX: begin
                received_at <= cur.time_ms;
                if (rx_gap > {16'd0, recovery_period_ms}) begin
                  link_flag <= 1'b1;
                  wr_flag   <= 1'b1;
                  wval_flag <= 1'b1;
                end
              end
              OP_FAIL: begin
                wr_flag   <= 1'b1;
                failed_at <= cur.time_ms;
                if (fail_gap > {16'd0, failure_period_ms}) begin
                  link_flag <= 1'b0;
                end
              end
              default: ;
            endcase
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (res_free) begin
            res_valid           <= 1'b1;
            res.phase           <= phase_reg;
            res.failsafe_active <= active_flag;
            res.link_up         <= link_flag;
            res.rx_flag_write   <= wr_flag;
            res.rx_flag_value   <= wval_flag;
            res.disarm_pulse    <= disarm_flag;
            res.event_count     <= activation_count;
            state               <= S_READY;
          end
        end

        default: state <= S_READY;
      endcase
    end
  end

endmodule

FILE: rtl/radio_link_failsafe_controller.sv
// channel | dir | handshake              | payload
// evt     | in  | evt_valid / evt_stall  | evt_t  (mode, time_ms, armed, throttle_down)
// res     | out | res_valid / res_stall  | res_t  (one result per event)
// cfg     | in  | cfg_write              | cfg_index, cfg_data
//
// Receive, fail and ignored events go through the back end's ready, exec and emit
// steps; an enabled update tick runs 1 to 4 phase-machine passes in exec.
// The back end runs one item at a time; a 2-entry queue lets the front keep
// accepting items while it works. rst (synchronous) loads the register defaults and
// clears control state, not stored data. A stalled result holds the back end in emit.
module radio_link_failsafe_controller import rlfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        evt_valid,
  output logic        evt_stall,
  input  evt_t        evt,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  queue_status_t q_status;
  logic          push;
  cmd_t          push_cmd;
  logic          pop;
  cmd_t          pop_cmd;

  rlfc_front u_front (
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  rlfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  rlfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

FILE: rtl/rlfc_checker.sv
module rlfc_checker import rlfc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_after_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_settled_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.phase == PH_IDLE || res.phase == PH_LANDED ||
                  res.phase == PH_MONITOR)
    else $error("unsettled phase reported");

  a_active_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.phase == PH_IDLE) == !res.failsafe_active)
    else $error("active flag disagrees with phase");

  a_flag_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.rx_flag_value |-> res.rx_flag_write)
    else $error("rx flag value without write");

endmodule

bind radio_link_failsafe_controller rlfc_checker u_rlfc_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
